// ===== sv/functional_graph_kth_successor_macros.svh =====
// assertion macros for the kth successor block
// used by files that assert on clk with synchronous reset rst
`ifndef FUNCTIONAL_GRAPH_KTH_SUCCESSOR_MACROS_SVH
`define FUNCTIONAL_GRAPH_KTH_SUCCESSOR_MACROS_SVH

// same-cycle implication
`define FGKS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FGKS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fgks_pkg.sv =====
// shared types and constants for the kth successor block
// no dependencies
package fgks_pkg;

  localparam int CMD_W      = 2;
  localparam int JUMP_W     = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_COUNT = 2'd0,
    CFG_NODE_COUNT = 2'd1
  } cfg_reg_t;

endpackage

// ===== sv/fgks_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module fgks_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 30720
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fgks_engine.sv =====
// load, build and query sequencer with result register
// depends on fgks_pkg and functional_graph_kth_successor_macros.svh
`include "functional_graph_kth_successor_macros.svh"

module fgks_engine #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 30,
  localparam int NODE_W   = $clog2(MAX_NODES + 1),
  localparam int IDX_W    = $clog2(MAX_NODES),
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int ADDR_W   = LVL_W + IDX_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fgks_pkg::CMD_W-1:0]  cmd,
  input  logic [NODE_W-1:0]           node,
  input  logic [NODE_W-1:0]           successor,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [NODE_W-1:0]           end_node,
  input  logic [fgks_pkg::JUMP_W-1:0] jump_count,
  input  logic [NODE_W-1:0]           node_count,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [NODE_W-1:0]           wr_data,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [NODE_W-1:0]           rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BRD1,
    S_BRD2,
    S_BWR,
    S_QSTEP,
    S_QLOAD,
    S_DONE
  } state_t;

  state_t              state;
  logic [LVL_W-1:0]    lvl;
  logic [NODE_W-1:0]   vtx;
  logic [NODE_W-1:0]   count;
  logic [NODE_W-1:0]   pos;
  logic [LEVELS-1:0]   bits;
  logic                ready;
  fgks_pkg::cmd_t      cmd_in;
  logic [NODE_W-1:0]   build_count;
  logic [LVL_W-1:0]    lvl_m1;
  logic                done_fire;
  logic                query_take;

  function automatic logic node_ok(input logic [NODE_W-1:0] v);
    return (v != '0) && (v <= NODE_W'(MAX_NODES));
  endfunction

  function automatic logic [IDX_W-1:0] idx_of(input logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] m;
    m = v - NODE_W'(1);
    return m[IDX_W-1:0];
  endfunction

  assign cmd_in      = fgks_pkg::cmd_t'(cmd);
  assign in_stall    = (state != S_IDLE);
  assign lvl_m1      = lvl - LVL_W'(1);
  assign build_count = (node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count;
  assign done_fire   = (state == S_DONE) && (!out_valid || !out_stall);
  assign query_take  = in_valid && !in_stall && (cmd_in == fgks_pkg::CMD_QUERY);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {lvl, idx_of(vtx)};
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = {lvl, idx_of(pos)};
    unique case (state)
      S_IDLE: begin
        if (in_valid && cmd_in == fgks_pkg::CMD_LOAD && node_ok(node)) begin
          wr_en   = 1'b1;
          wr_addr = {LVL_W'(0), idx_of(node)};
          wr_data = successor;
        end
      end
      S_BRD1: begin
        rd_en   = 1'b1;
        rd_addr = {lvl_m1, idx_of(vtx)};
      end
      S_BRD2: begin
        rd_en   = 1'b1;
        rd_addr = {lvl_m1, idx_of(rd_data)};
      end
      S_BWR: begin
        wr_en   = 1'b1;
        wr_data = node_ok(pos) ? rd_data : '0;
      end
      S_QSTEP: begin
        rd_en = bits[LEVELS-1] && node_ok(pos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ready     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (done_fire) begin
        out_valid <= 1'b1;
        end_node  <= pos;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (cmd_in)
              fgks_pkg::CMD_LOAD: begin
                if (node_ok(node)) begin
                  ready <= 1'b0;
                end
              end
              fgks_pkg::CMD_BUILD: begin
                if (LEVELS == 1 || build_count == '0) begin
                  ready <= 1'b1;
                end else begin
                  lvl   <= LVL_W'(1);
                  vtx   <= NODE_W'(1);
                  count <= build_count;
                  state <= S_BRD1;
                end
              end
              fgks_pkg::CMD_QUERY: begin
                if (ready && node_ok(node)) begin
                  pos   <= node;
                  bits  <= LEVELS'(jump_count);
                  lvl   <= LVL_W'(LEVELS - 1);
                  state <= S_QSTEP;
                end else begin
                  pos   <= '0;
                  state <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_BRD1: begin
          state <= S_BRD2;
        end
        S_BRD2: begin
          pos   <= rd_data;
          state <= S_BWR;
        end
        S_BWR: begin
          if (vtx == count) begin
            if (lvl == LVL_W'(LEVELS - 1)) begin
              ready <= 1'b1;
              state <= S_IDLE;
            end else begin
              lvl   <= lvl + LVL_W'(1);
              vtx   <= NODE_W'(1);
              state <= S_BRD1;
            end
          end else begin
            vtx   <= vtx + NODE_W'(1);
            state <= S_BRD1;
          end
        end
        S_QSTEP: begin
          if (bits[LEVELS-1] && node_ok(pos)) begin
            state <= S_QLOAD;
          end else begin
            if (bits[LEVELS-1]) begin
              pos <= '0;
            end
            bits <= bits << 1;
            if (lvl == '0) begin
              state <= S_DONE;
            end else begin
              lvl <= lvl - LVL_W'(1);
            end
          end
        end
        S_QLOAD: begin
          pos  <= rd_data;
          bits <= bits << 1;
          if (lvl == '0) begin
            state <= S_DONE;
          end else begin
            lvl   <= lvl - LVL_W'(1);
            state <= S_QSTEP;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FGKS_ASSERT_IMP(a_write_only_load_build, wr_en, state == S_IDLE || state == S_BWR, "bad write")
  `FGKS_ASSERT_IMP(a_build_level_nonzero, state == S_BWR, lvl != '0, "build writes level zero")
  `FGKS_ASSERT_NXT(a_query_leaves_idle, query_take, state != S_IDLE, "query did not start")
  `FGKS_ASSERT_IMP(a_result_from_done, $rose(out_valid), $past(state) == S_DONE, "stray result")

endmodule

// ===== sv/functional_graph_kth_successor.sv =====
// Kth successor on a functional graph by binary lifting. A load (cmd 0) writes one level-0
// successor; a build (cmd 1) fills levels 1 to LEVELS-1 for nodes 1 to node_count, stepping
// each entry through S_BRD1, S_BRD2 and S_BWR, since each entry takes two dependent reads and
// one write on the single read port of the jump table; a query (cmd 2) scans the low LEVELS
// bits of jump_count from the top, one bit per S_QSTEP, with an extra S_QLOAD table read for
// each set bit met while on a valid node, and end_node is registered from S_DONE. An invalid
// start, or a query before a build or after a load since the last build, returns 0. The table
// has no clearing pass; entries are meaningful only after being written. The user must write
// config only while the block is idle; the block itself does not enforce this.
// depends on fgks_pkg, fgks_ram and fgks_engine
module functional_graph_kth_successor #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 30,
  localparam int NODE_W   = $clog2(MAX_NODES + 1),
  localparam int IDX_W    = $clog2(MAX_NODES),
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int ADDR_W   = LVL_W + IDX_W,
  localparam int DEPTH    = LEVELS * (2 ** IDX_W)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fgks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgks_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fgks_pkg::CMD_W-1:0]      cmd,
  input  logic [NODE_W-1:0]               node,
  input  logic [NODE_W-1:0]               successor,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [NODE_W-1:0]               end_node
);

  logic [fgks_pkg::JUMP_W-1:0] jump_count;
  logic [NODE_W-1:0]           node_count;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [NODE_W-1:0]           wr_data;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic [NODE_W-1:0]           rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_count <= '0;
      node_count <= NODE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (fgks_pkg::cfg_reg_t'(cfg_index))
        fgks_pkg::CFG_JUMP_COUNT: jump_count <= cfg_data[fgks_pkg::JUMP_W-1:0];
        fgks_pkg::CFG_NODE_COUNT: node_count <= cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  fgks_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fgks_engine #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .node       (node),
    .successor  (successor),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .end_node   (end_node),
    .jump_count (jump_count),
    .node_count (node_count),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

endmodule

// ===== tb/functional_graph_kth_successor_check.sv =====
// checker for the kth successor block: mirrors the jump table and registers from the
// observed requests, predicts each end_node and compares it with the accepted result
// depends on fgks_pkg
module functional_graph_kth_successor_check #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 30,
  localparam int NODE_W   = $clog2(MAX_NODES + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fgks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgks_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [fgks_pkg::CMD_W-1:0]      cmd,
  input  logic [NODE_W-1:0]               node,
  input  logic [NODE_W-1:0]               successor,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [NODE_W-1:0]               end_node,
  output int                              mismatches,
  output int                              open_queries
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [NODE_W-1:0]           lift_table [1:MAX_NODES][0:LEVELS-1];
  logic                        lifted_ready = 1'b0;
  logic [fgks_pkg::JUMP_W-1:0] steps = '0;
  logic [NODE_W-1:0]           span = NODE_W'(1);
  logic [NODE_W-1:0]           end_node_q [$];
  int                          miss_count = 0;
  int                          pending_n = 0;

  assign mismatches   = miss_count;
  assign open_queries = pending_n;

  function automatic logic [NODE_W-1:0] hop(input logic [NODE_W-1:0] v, input int lvl);
    if (v < 1 || v > MAX_NODES) return '0;
    return lift_table[v][lvl];
  endfunction

  function automatic void rebuild();
    int top_node;
    top_node = (span > MAX_NODES) ? MAX_NODES : span;
    for (int lvl = 1; lvl < LEVELS; lvl++)
      for (int v = 1; v <= top_node; v++)
        lift_table[v][lvl] = hop(hop(NODE_W'(v), lvl - 1), lvl - 1);
    lifted_ready = 1'b1;
  endfunction

  function automatic logic [NODE_W-1:0] walk(input logic [NODE_W-1:0] start);
    logic [NODE_W-1:0] pos;
    pos = start;
    if (!lifted_ready || start < 1 || start > MAX_NODES) return '0;
    for (int b = LEVELS - 1; b >= 0; b--)
      if (b < fgks_pkg::JUMP_W && steps[b]) pos = hop(pos, b);
    return pos;
  endfunction

  always @(posedge clk) begin
    logic [NODE_W-1:0] want;
    if (rst) begin
      lifted_ready = 1'b0;
      steps = '0;
      span = NODE_W'(1);
      end_node_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (end_node_q.size() == 0) begin
          $display("%0t: end_node expected none actual %0d", $time, end_node);
          miss_count++;
        end else begin
          want = end_node_q.pop_front();
          if (end_node !== want) begin
            $display("%0t: end_node expected %0d actual %0d", $time, want, end_node);
            miss_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fgks_pkg::CFG_JUMP_COUNT) steps = cfg_data[fgks_pkg::JUMP_W-1:0];
        else if (cfg_index == fgks_pkg::CFG_NODE_COUNT) span = cfg_data[NODE_W-1:0];
      end
      if (in_valid && !in_stall) begin
        case (cmd)
          fgks_pkg::CMD_LOAD: begin
            if (node >= 1 && node <= MAX_NODES) begin
              lift_table[node][0] = successor;
              lifted_ready = 1'b0;
            end
          end
          fgks_pkg::CMD_BUILD: rebuild();
          fgks_pkg::CMD_QUERY: end_node_q.push_back(walk(node));
          default: ;
        endcase
      end
    end
    pending_n = end_node_q.size();
  end

endmodule

// ===== tb/functional_graph_kth_successor_test.sv =====
// top of the kth successor testbench: clock, reset, request and stall generation, verdict
// depends on fgks_pkg, functional_graph_kth_successor and functional_graph_kth_successor_check
module functional_graph_kth_successor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES      = 1024;
  localparam int LEVELS         = 30;
  localparam int NODE_W         = $clog2(MAX_NODES + 1);
  localparam int NODE_FIELD_MAX = 2 ** NODE_W - 1;
  localparam int ITEM_TARGET    = 1150;
  localparam int FULL_ITEMS     = MAX_NODES + 52;
  localparam logic [fgks_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [fgks_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fgks_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fgks_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [fgks_pkg::CMD_W-1:0]      cmd = fgks_pkg::CMD_NOP;
  logic [NODE_W-1:0]               node = '0;
  logic [NODE_W-1:0]               successor = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [NODE_W-1:0]               end_node;
  int                              mismatches;
  int                              open_queries;

  int   send_pct = 26;
  int   recv_pct = 79;
  int   items = 0;
  int   succ_of [1:MAX_NODES] = '{default: 0};
  int   nc_m = 1;
  int   safe_hi = 0;
  int   last_build_count = 0;
  logic ready_m = 1'b0;
  logic build_open = 1'b0;

  functional_graph_kth_successor DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .node(node), .successor(successor),
    .out_valid(out_valid), .out_stall(out_stall), .end_node(end_node)
  );

  functional_graph_kth_successor_check #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) scoreboard (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .node(node), .successor(successor),
    .out_valid(out_valid), .out_stall(out_stall), .end_node(end_node),
    .mismatches(mismatches), .open_queries(open_queries)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_pct);

  function automatic void set_idle(input int mode);
    send_pct = (mode == 0) ? 26 : (mode == 1) ? 79 : 0;
    recv_pct = (mode == 0) ? 79 : (mode == 1) ? 26 : 0;
  endfunction

  function automatic int rand11();
    return $urandom_range(0, NODE_FIELD_MAX);
  endfunction

  function automatic int bad_node();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_NODES + 1, NODE_FIELD_MAX);
  endfunction

  function automatic int pick_start();
    if ($urandom_range(0, 99) < 8) return bad_node();
    if (ready_m && safe_hi > 0) return $urandom_range(1, safe_hi);
    return $urandom_range(1, MAX_NODES);
  endfunction

  function automatic logic [fgks_pkg::JUMP_W-1:0] pick_jump();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return fgks_pkg::JUMP_W'(1) << $urandom_range(0, fgks_pkg::JUMP_W - 1);
      default: return fgks_pkg::JUMP_W'($urandom());
    endcase
  endfunction

  task automatic send(input fgks_pkg::cmd_t op, input int n, input int s);
    set_idle(items < ITEM_TARGET / 3 ? 0 : items < 2 * ITEM_TARGET / 3 ? 1 : 2);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    node      <= NODE_W'(n);
    successor <= NODE_W'(s);
    do @(posedge clk); while (in_stall);
    case (op)
      fgks_pkg::CMD_LOAD: begin
        if (n >= 1 && n <= MAX_NODES) begin
          succ_of[n] = s;
          ready_m = 1'b0;
          items++;
        end
      end
      fgks_pkg::CMD_BUILD: begin
        last_build_count = (nc_m > MAX_NODES) ? MAX_NODES : nc_m;
        if (last_build_count != 0) safe_hi = last_build_count;
        ready_m = 1'b1;
        build_open = 1'b1;
        items++;
      end
      fgks_pkg::CMD_QUERY: begin
        build_open = 1'b0;
        items++;
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [fgks_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fgks_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == fgks_pkg::CFG_NODE_COUNT) nc_m = data[NODE_W-1:0];
  endtask

  // hold off requests until every query has answered and any build has finished
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_queries != 0) @(posedge clk);
    repeat (build_open ? 3 * LEVELS * last_build_count + 64 : 16) @(posedge clk);
    build_open = 1'b0;
  endtask

  task automatic write_count(input int n);
    logic [fgks_pkg::CFG_DATA_W-1:0] data;
    data = fgks_pkg::CFG_DATA_W'($urandom());
    data[NODE_W-1:0] = NODE_W'(n);
    write_reg(fgks_pkg::CFG_NODE_COUNT, data);
  endtask

  task automatic run_phase(input int n, input int n_ops);
    int r;
    if ($urandom_range(0, 1)) begin
      write_reg(fgks_pkg::CFG_JUMP_COUNT, pick_jump());
      write_count(n);
    end else begin
      write_count(n);
      write_reg(fgks_pkg::CFG_JUMP_COUNT, pick_jump());
    end
    if ($urandom_range(0, 9) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                fgks_pkg::CFG_DATA_W'($urandom()));
    repeat ($urandom_range(0, 2)) send(fgks_pkg::CMD_QUERY, pick_start(), rand11());
    // every node in range must point inside the range before a build
    for (int v = 1; v <= n; v++)
      if (succ_of[v] == 0 || succ_of[v] > n)
        send(fgks_pkg::CMD_LOAD, v, $urandom_range(1, n));
    repeat ($urandom_range(0, 3))
      send(fgks_pkg::CMD_LOAD, $urandom_range(1, n), $urandom_range(1, n));
    send(fgks_pkg::CMD_BUILD, rand11(), rand11());
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if (r < 62) send(fgks_pkg::CMD_QUERY, pick_start(), rand11());
      else if (r < 77) send(fgks_pkg::CMD_LOAD, $urandom_range(1, n), $urandom_range(1, n));
      else if (r < 85) send(fgks_pkg::CMD_BUILD, rand11(), rand11());
      else if (r < 92)
        send(fgks_pkg::CMD_LOAD, (n < MAX_NODES && $urandom_range(0, 1)) ?
             $urandom_range(n + 1, MAX_NODES) : bad_node(), $urandom_range(1, MAX_NODES));
      else send(fgks_pkg::CMD_NOP, rand11(), rand11());
    end
    settle();
  endtask

  task automatic full_graph_phase();
    write_reg(fgks_pkg::CFG_JUMP_COUNT, pick_jump());
    write_count(MAX_NODES);
    for (int v = 1; v <= MAX_NODES; v++)
      send(fgks_pkg::CMD_LOAD, v, $urandom_range(1, MAX_NODES));
    send(fgks_pkg::CMD_BUILD, rand11(), rand11());
    repeat (30) send(fgks_pkg::CMD_QUERY, pick_start(), rand11());
    settle();
    // count above the node range is clipped to the full table
    write_reg(fgks_pkg::CFG_JUMP_COUNT, '1);
    write_reg(fgks_pkg::CFG_NODE_COUNT, fgks_pkg::CFG_DATA_W'(NODE_FIELD_MAX));
    send(fgks_pkg::CMD_BUILD, rand11(), rand11());
    repeat (20) send(fgks_pkg::CMD_QUERY, pick_start(), rand11());
    settle();
  endtask

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int n;
    set_idle(0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default registers: no steps, single node
    send(fgks_pkg::CMD_QUERY, 1, rand11());
    send(fgks_pkg::CMD_LOAD, MAX_NODES, MAX_NODES);
    send(fgks_pkg::CMD_LOAD, 1, 1);
    send(fgks_pkg::CMD_LOAD, 0, 5);
    send(fgks_pkg::CMD_LOAD, NODE_FIELD_MAX, 3);
    send(fgks_pkg::CMD_BUILD, 0, 0);
    send(fgks_pkg::CMD_NOP, NODE_FIELD_MAX, NODE_FIELD_MAX);
    send(fgks_pkg::CMD_QUERY, 1, 0);
    send(fgks_pkg::CMD_QUERY, MAX_NODES, NODE_FIELD_MAX);
    send(fgks_pkg::CMD_QUERY, 0, 0);
    send(fgks_pkg::CMD_QUERY, NODE_FIELD_MAX, 0);
    send(fgks_pkg::CMD_LOAD, 0, 9);
    send(fgks_pkg::CMD_QUERY, 1, 0);
    settle();

    // four node ring, all steps
    write_reg(fgks_pkg::CFG_JUMP_COUNT, '1);
    write_count(4);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, fgks_pkg::CFG_DATA_W'($urandom()));
    send(fgks_pkg::CMD_LOAD, 1, 2);
    send(fgks_pkg::CMD_LOAD, 2, 3);
    send(fgks_pkg::CMD_LOAD, 3, 4);
    send(fgks_pkg::CMD_LOAD, 4, 1);
    send(fgks_pkg::CMD_BUILD, 0, 0);
    send(fgks_pkg::CMD_QUERY, 1, 0);
    send(fgks_pkg::CMD_QUERY, 4, 0);
    settle();

    // zero count builds nothing and keeps the old levels
    write_reg(fgks_pkg::CFG_NODE_COUNT,
              {{(fgks_pkg::CFG_DATA_W - NODE_W){1'b1}}, {NODE_W{1'b0}}});
    write_reg(fgks_pkg::CFG_JUMP_COUNT, fgks_pkg::JUMP_W'(5));
    send(fgks_pkg::CMD_BUILD, 0, 0);
    send(fgks_pkg::CMD_QUERY, 2, 0);
    send(fgks_pkg::CMD_QUERY, 3, 0);
    settle();

    while (items < ITEM_TARGET - FULL_ITEMS) begin
      n = $urandom_range(0, 99);
      n = (n < 70) ? $urandom_range(1, 8) : (n < 92) ? $urandom_range(9, 32) :
          $urandom_range(33, 96);
      run_phase(n, $urandom_range(8, 40));
    end
    full_graph_phase();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
